[sv/song_binary_stream_decoder_top_assert.svh]
// Assertion macros for the song stream decoder checker.
// Included by sbsd_checker.sv; depends on nothing else.
`ifndef SONG_BINARY_STREAM_DECODER_TOP_ASSERT_SVH
`define SONG_BINARY_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBSD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sbsd_pkg.sv]
// Types and constants of the song stream decoder.
// Used by sbsd_core, the top level and the checker; depends on nothing.
package sbsd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_DRUMS  = 3'd2,
    PH_ILEN   = 3'd3,
    PH_ITEXT  = 3'd4,
    PH_OPCODE = 3'd5,
    PH_ARGS   = 3'd6,
    PH_FAILED = 3'd7
  } phase_e;

  typedef enum logic [3:0] {
    KIND_HEADER      = 4'd0,
    KIND_DRUM_ID     = 4'd1,
    KIND_INSTR_START = 4'd2,
    KIND_NAME_BYTE   = 4'd3,
    KIND_BEAT        = 4'd4,
    KIND_NOTE        = 4'd5,
    KIND_DRUM_HIT    = 4'd6,
    KIND_ASSIGN      = 4'd7,
    KIND_GLISS       = 4'd8,
    KIND_END         = 4'd9,
    KIND_ERROR       = 4'd10
  } kind_e;

  // Error codes carried in arg0 of an error record.
  localparam logic [7:0] ERR_HDR_SHORT = 8'd0;
  localparam logic [7:0] ERR_SIGNATURE = 8'd1;
  localparam logic [7:0] ERR_TEMPO     = 8'd2;
  localparam logic [7:0] ERR_LENGTH    = 8'd3;
  localparam logic [7:0] ERR_TRUNC     = 8'd4;
  localparam logic [7:0] ERR_OPCODE    = 8'd5;

  // Command opcodes.
  localparam logic [2:0] OP_NOOP   = 3'd0;
  localparam logic [2:0] OP_BEAT   = 3'd1;
  localparam logic [2:0] OP_NOTE   = 3'd2;
  localparam logic [2:0] OP_DRUM   = 3'd3;
  localparam logic [2:0] OP_ASSIGN = 3'd4;
  localparam logic [2:0] OP_GLISS  = 3'd5;

  // Argument bytes per command.
  localparam logic [2:0] NEED_NOTE   = 3'd5;
  localparam logic [2:0] NEED_DRUM   = 3'd3;
  localparam logic [2:0] NEED_ASSIGN = 3'd1;
  localparam logic [2:0] NEED_GLISS  = 3'd3;

  // Byte positions inside the fixed 16-byte header.
  localparam logic [3:0] SIG_LEN       = 4'd8;
  localparam logic [3:0] HPOS_TEMPO_HI = 4'd8;
  localparam logic [3:0] HPOS_TEMPO_LO = 4'd9;
  localparam logic [3:0] HPOS_DRUMS    = 4'd10;
  localparam logic [3:0] HPOS_INSTR    = 4'd11;
  localparam logic [3:0] HPOS_LEN0     = 4'd12;
  localparam logic [3:0] HPOS_LAST     = 4'd15;

  localparam logic [7:0] SIGNATURE [8] = '{
    8'h00, 8'h50, 8'h53, 8'hFF, 8'h53, 8'h4F, 8'h4E, 8'h47
  };

  typedef struct packed {
    kind_e       kind;
    logic [15:0] tempo;
    logic [7:0]  arg0;
    logic [7:0]  arg1;
    logic [7:0]  arg2;
    logic [7:0]  arg3;
    logic [7:0]  arg4;
    logic        file_done;
  } rec_t;

endpackage

[sv/sbsd_if.sv]
// Valid/ready stream interfaces for the song stream decoder.
// Depends on nothing; used by the top level.
interface sbsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface sbsd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [15:0] tempo;
  logic [7:0]  arg0;
  logic [7:0]  arg1;
  logic [7:0]  arg2;
  logic [7:0]  arg3;
  logic [7:0]  arg4;
  logic        file_done;

  modport source (output valid, output kind, output tempo, output arg0, output arg1,
                  output arg2, output arg3, output arg4, output file_done, input ready);
  modport sink   (input valid, input kind, input tempo, input arg0, input arg1,
                  input arg2, input arg3, input arg4, input file_done, output ready);
endinterface

[sv/sbsd_core.sv]
// Parser state and per-byte decode of the song stream decoder.
// Depends on sbsd_pkg.
module sbsd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             final_byte_i,
  output logic             have_o,
  output sbsd_pkg::rec_t   rec_o
);

  sbsd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hpos_q, hpos_d;
  logic [15:0] tempo_q, tempo_d;
  logic [7:0]  drum_q, drum_d;
  logic [7:0]  instr_q, instr_d;
  logic [31:0] skip_q, skip_d;
  logic [7:0]  items_q, items_d;
  logic [7:0]  text_q, text_d;
  logic [2:0]  opcode_q, opcode_d;
  logic [2:0]  argcnt_q, argcnt_d;
  logic        sig_bad_q, sig_bad_d;
  logic [7:0]  store_q [4];

  logic        store_we;
  logic        err;
  logic [7:0]  err_code;
  sbsd_pkg::rec_t rec;
  logic        have;

  // Phase this byte leads to, before an end of file sends the parser back to the header.
  sbsd_pkg::phase_e step_phase;

  // Where the stream goes once the extra header is behind us.
  sbsd_pkg::phase_e drums_phase;
  logic [7:0]       drums_items;
  // Command decode for the argument phase.
  sbsd_pkg::kind_e  cmd_kind;
  logic [2:0]       cmd_need;
  logic             args_last;
  logic [7:0]       args [5];

  always_comb begin
    if (drum_q != 8'd0) begin
      drums_phase = sbsd_pkg::PH_DRUMS;
      drums_items = drum_q;
    end else if (instr_q != 8'd0) begin
      drums_phase = sbsd_pkg::PH_ILEN;
      drums_items = instr_q;
    end else begin
      drums_phase = sbsd_pkg::PH_OPCODE;
      drums_items = items_q;
    end
  end

  always_comb begin
    case (opcode_q)
      sbsd_pkg::OP_NOTE: begin
        cmd_kind = sbsd_pkg::KIND_NOTE;
        cmd_need = sbsd_pkg::NEED_NOTE;
      end
      sbsd_pkg::OP_DRUM: begin
        cmd_kind = sbsd_pkg::KIND_DRUM_HIT;
        cmd_need = sbsd_pkg::NEED_DRUM;
      end
      sbsd_pkg::OP_ASSIGN: begin
        cmd_kind = sbsd_pkg::KIND_ASSIGN;
        cmd_need = sbsd_pkg::NEED_ASSIGN;
      end
      sbsd_pkg::OP_GLISS: begin
        cmd_kind = sbsd_pkg::KIND_GLISS;
        cmd_need = sbsd_pkg::NEED_GLISS;
      end
      default: begin
        cmd_kind = sbsd_pkg::KIND_HEADER;
        cmd_need = sbsd_pkg::NEED_GLISS;
      end
    endcase
  end

  assign args_last = (argcnt_q + 3'd1) >= cmd_need;

  // Stored bytes below the count, the current byte at the count, zero above.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < argcnt_q) begin
        args[i] = store_q[i];
      end else if (3'(i) == argcnt_q) begin
        args[i] = data_byte_i;
      end else begin
        args[i] = 8'h00;
      end
    end
    args[4] = (argcnt_q == 3'd4) ? data_byte_i : 8'h00;
  end

  // Next state.
  always_comb begin
    step_phase = phase_q;
    hpos_d     = hpos_q;
    tempo_d    = tempo_q;
    drum_d     = drum_q;
    instr_d    = instr_q;
    skip_d     = skip_q;
    items_d    = items_q;
    text_d     = text_q;
    opcode_d   = opcode_q;
    argcnt_d   = argcnt_q;
    sig_bad_d  = sig_bad_q;
    store_we   = 1'b0;
    err        = 1'b0;
    err_code   = sbsd_pkg::ERR_HDR_SHORT;

    case (phase_q)
      sbsd_pkg::PH_HEADER: begin
        if ((hpos_q < sbsd_pkg::SIG_LEN) &&
            (data_byte_i != sbsd_pkg::SIGNATURE[hpos_q[2:0]])) begin
          sig_bad_d = 1'b1;
        end
        case (hpos_q)
          sbsd_pkg::HPOS_TEMPO_HI: tempo_d = {data_byte_i, 8'h00};
          sbsd_pkg::HPOS_TEMPO_LO: tempo_d = tempo_q | {8'h00, data_byte_i};
          sbsd_pkg::HPOS_DRUMS:    drum_d  = data_byte_i;
          sbsd_pkg::HPOS_INSTR:    instr_d = data_byte_i;
          default: begin
            if (hpos_q >= sbsd_pkg::HPOS_LEN0) skip_d = {skip_q[23:0], data_byte_i};
          end
        endcase
        if (hpos_q == sbsd_pkg::HPOS_LAST) begin
          // Checks in order: signature, tempo, extra-header length.
          if (sig_bad_q) begin
            err      = 1'b1;
            err_code = sbsd_pkg::ERR_SIGNATURE;
          end else if (tempo_q == 16'd0) begin
            err      = 1'b1;
            err_code = sbsd_pkg::ERR_TEMPO;
          end else if (skip_d[31]) begin
            err      = 1'b1;
            err_code = sbsd_pkg::ERR_LENGTH;
          end else if (skip_d != 32'd0) begin
            step_phase = sbsd_pkg::PH_SKIP;
          end else begin
            step_phase = drums_phase;
            items_d    = drums_items;
          end
        end else begin
          hpos_d = hpos_q + 4'd1;
        end
      end
      sbsd_pkg::PH_SKIP: begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          step_phase = drums_phase;
          items_d    = drums_items;
        end
      end
      sbsd_pkg::PH_DRUMS: begin
        items_d = items_q - 8'd1;
        if (items_q == 8'd1) begin
          if (instr_q != 8'd0) begin
            items_d    = instr_q;
            step_phase = sbsd_pkg::PH_ILEN;
          end else begin
            step_phase = sbsd_pkg::PH_OPCODE;
          end
        end
      end
      sbsd_pkg::PH_ILEN: begin
        if (data_byte_i != 8'd0) begin
          text_d     = data_byte_i;
          step_phase = sbsd_pkg::PH_ITEXT;
        end else begin
          items_d    = items_q - 8'd1;
          step_phase = (items_q == 8'd1) ? sbsd_pkg::PH_OPCODE : sbsd_pkg::PH_ILEN;
        end
      end
      sbsd_pkg::PH_ITEXT: begin
        text_d = text_q - 8'd1;
        if (text_q == 8'd1) begin
          items_d    = items_q - 8'd1;
          step_phase = (items_q == 8'd1) ? sbsd_pkg::PH_OPCODE : sbsd_pkg::PH_ILEN;
        end
      end
      sbsd_pkg::PH_OPCODE: begin
        // Noop and beat leave the parser where it is.
        if (data_byte_i > {5'd0, sbsd_pkg::OP_GLISS}) begin
          err      = 1'b1;
          err_code = sbsd_pkg::ERR_OPCODE;
        end else if (data_byte_i > {5'd0, sbsd_pkg::OP_BEAT}) begin
          opcode_d   = data_byte_i[2:0];
          argcnt_d   = 3'd0;
          step_phase = sbsd_pkg::PH_ARGS;
        end
      end
      sbsd_pkg::PH_ARGS: begin
        if (args_last) begin
          argcnt_d   = 3'd0;
          step_phase = sbsd_pkg::PH_OPCODE;
        end else begin
          store_we = 1'b1;
          argcnt_d = argcnt_q + 3'd1;
        end
      end
      default: begin
        // Failed: swallow bytes up to the end of the file.
      end
    endcase

    if (err) step_phase = sbsd_pkg::PH_FAILED;
    phase_d = step_phase;

    // Every file end, clean or not, restarts the parser.
    if (final_byte_i) begin
      phase_d   = sbsd_pkg::PH_HEADER;
      hpos_d    = 4'd0;
      tempo_d   = 16'd0;
      drum_d    = 8'd0;
      instr_d   = 8'd0;
      skip_d    = 32'd0;
      items_d   = 8'd0;
      text_d    = 8'd0;
      opcode_d  = 3'd0;
      argcnt_d  = 3'd0;
      sig_bad_d = 1'b0;
    end
  end

  // Record for the current byte.
  always_comb begin
    rec  = '0;
    have = 1'b0;

    case (phase_q)
      sbsd_pkg::PH_HEADER: begin
        if (hpos_q == sbsd_pkg::HPOS_LAST) begin
          have      = 1'b1;
          rec.kind  = sbsd_pkg::KIND_HEADER;
          rec.tempo = tempo_q;
          rec.arg0  = drum_q;
          rec.arg1  = instr_q;
        end
      end
      sbsd_pkg::PH_DRUMS: begin
        have     = 1'b1;
        rec.kind = sbsd_pkg::KIND_DRUM_ID;
        rec.arg0 = data_byte_i;
        rec.arg1 = drum_q - items_q;
      end
      sbsd_pkg::PH_ILEN: begin
        have     = 1'b1;
        rec.kind = sbsd_pkg::KIND_INSTR_START;
        rec.arg0 = data_byte_i;
        rec.arg1 = instr_q - items_q;
      end
      sbsd_pkg::PH_ITEXT: begin
        have     = 1'b1;
        rec.kind = sbsd_pkg::KIND_NAME_BYTE;
        rec.arg0 = data_byte_i;
        rec.arg1 = instr_q - items_q;
      end
      sbsd_pkg::PH_OPCODE: begin
        if (data_byte_i == {5'd0, sbsd_pkg::OP_BEAT}) begin
          have     = 1'b1;
          rec.kind = sbsd_pkg::KIND_BEAT;
        end
      end
      sbsd_pkg::PH_ARGS: begin
        if (args_last) begin
          have     = 1'b1;
          rec.kind = cmd_kind;
          rec.arg0 = args[0];
          rec.arg1 = args[1];
          rec.arg2 = args[2];
          rec.arg3 = args[3];
          rec.arg4 = args[4];
        end
      end
      default: begin
        // Failed: no record.
      end
    endcase

    if (err) begin
      rec           = '0;
      rec.kind      = sbsd_pkg::KIND_ERROR;
      rec.arg0      = err_code;
      rec.file_done = 1'b1;
      have          = 1'b1;
    end else if (final_byte_i && (phase_q != sbsd_pkg::PH_FAILED)) begin
      if (step_phase == sbsd_pkg::PH_OPCODE) begin
        if (!have) begin
          rec      = '0;
          rec.kind = sbsd_pkg::KIND_END;
        end
      end else begin
        rec      = '0;
        rec.kind = sbsd_pkg::KIND_ERROR;
        rec.arg0 = (step_phase == sbsd_pkg::PH_HEADER) ? sbsd_pkg::ERR_HDR_SHORT
                                                      : sbsd_pkg::ERR_TRUNC;
      end
      rec.file_done = 1'b1;
      have          = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sbsd_pkg::PH_HEADER;
      hpos_q    <= 4'd0;
      tempo_q   <= 16'd0;
      drum_q    <= 8'd0;
      instr_q   <= 8'd0;
      skip_q    <= 32'd0;
      items_q   <= 8'd0;
      text_q    <= 8'd0;
      opcode_q  <= 3'd0;
      argcnt_q  <= 3'd0;
      sig_bad_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      hpos_q    <= hpos_d;
      tempo_q   <= tempo_d;
      drum_q    <= drum_d;
      instr_q   <= instr_d;
      skip_q    <= skip_d;
      items_q   <= items_d;
      text_q    <= text_d;
      opcode_q  <= opcode_d;
      argcnt_q  <= argcnt_d;
      sig_bad_q <= sig_bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && store_we) store_q[argcnt_q[1:0]] <= data_byte_i;
  end

  assign have_o = have;
  assign rec_o  = rec;

endmodule

[sv/song_binary_stream_decoder_top.sv]
// Top level of the song stream decoder: input register, decode core, result register.
// Depends on sbsd_pkg, sbsd_if (sbsd_in_if, sbsd_out_if) and sbsd_core.
//
//   channel   dir   transaction payload
//   in_i      in    data_byte, final_byte (one file byte)
//   out_o     out   kind, tempo, arg0..arg4, file_done (one record)
//
// One byte is taken per cycle while out_o is not stalling; its record passes
// through the input register, then the result register, before it is presented
// on out_o.
// Bytes that produce no record (signature, extra header, noop, error tail) only
// advance the parser state.
// Reset clears the parser to the header phase and empties both registers.
// A stalled result register holds its record; the input register keeps taking
// bytes until it is full too, then in_i.ready stays low until out_o drains.
module song_binary_stream_decoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  sbsd_in_if.sink           in_i,
  sbsd_out_if.source        out_o
);

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_final_q;

  // Result register.
  logic           out_valid_q, out_valid_d;
  sbsd_pkg::rec_t out_rec_q;

  logic           advance;
  logic           have;
  sbsd_pkg::rec_t rec;

  // Move the held byte through decode when the result register can take its record.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.valid && in_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = have;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  sbsd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .data_byte_i  (in_byte_q),
    .final_byte_i (in_final_q),
    .have_o       (have),
    .rec_o        (rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on transaction, no reset.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q  <= in_i.data_byte;
      in_final_q <= in_i.final_byte;
    end
    if (advance && have) begin
      out_rec_q <= rec;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_rec_q.kind;
  assign out_o.tempo     = out_rec_q.tempo;
  assign out_o.arg0      = out_rec_q.arg0;
  assign out_o.arg1      = out_rec_q.arg1;
  assign out_o.arg2      = out_rec_q.arg2;
  assign out_o.arg3      = out_rec_q.arg3;
  assign out_o.arg4      = out_rec_q.arg4;
  assign out_o.file_done = out_rec_q.file_done;

endmodule

[sv/sbsd_checker.sv]
// Port-level checks of the song stream decoder, bound to the top level.
// Depends on sbsd_pkg and song_binary_stream_decoder_top_assert.svh.
`include "song_binary_stream_decoder_top_assert.svh"

module sbsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  out_kind_i,
  input logic [15:0] out_tempo_i,
  input logic [7:0]  out_arg0_i,
  input logic        out_done_i
);

  `SBSD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_tempo_i) && $stable(out_arg0_i) && $stable(out_done_i), "stalled record changed")
  `SBSD_ASSERT_IMP(a_err_closes, clk_i, rst_ni, out_valid_i && (out_kind_i == sbsd_pkg::KIND_ERROR), out_done_i && (out_tempo_i == 16'd0), "error record must close the file")
  `SBSD_ASSERT_IMP(a_end_closes, clk_i, rst_ni, out_valid_i && (out_kind_i == sbsd_pkg::KIND_END), out_done_i, "end record must close the file")
  `SBSD_ASSERT_IMP(a_hdr_tempo, clk_i, rst_ni, out_valid_i && (out_kind_i == sbsd_pkg::KIND_HEADER), out_tempo_i != 16'd0, "header record with zero tempo")
  `SBSD_ASSERT_IMP(a_err_code, clk_i, rst_ni, out_valid_i && (out_kind_i == sbsd_pkg::KIND_ERROR), out_arg0_i <= sbsd_pkg::ERR_OPCODE, "error code out of range")

endmodule

bind song_binary_stream_decoder_top sbsd_checker u_sbsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_tempo_i (out_o.tempo),
  .out_arg0_i  (out_o.arg0),
  .out_done_i  (out_o.file_done)
);
